/* sv/fwrl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fwrl_pkg;

    localparam int TRACKED_ENTRIES = 16;
    localparam int IDX_W = (TRACKED_ENTRIES > 1) ? $clog2(TRACKED_ENTRIES) : 1;

    localparam int ADDR_W   = 32;
    localparam int TIME_W   = 32;
    localparam int LIMIT_W  = 16;
    localparam int COUNT_W  = LIMIT_W + 1;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_REQUESTS = 1'b1;

    localparam logic [TIME_W-1:0]  WINDOW_MS_RESET    = 32'd60000;
    localparam logic [LIMIT_W-1:0] MAX_REQUESTS_RESET = 16'd60;

    localparam logic MODE_CHECK = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] ip_addr;
        logic [TIME_W-1:0] now_ms;
    } req_t;

    typedef struct packed {
        logic allowed;
        logic found;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CALC,
        ST_UPDATE
    } state_t;

endpackage

`default_nettype wire

/* sv/per_key_fixed_window_rate_limiter_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Per-address fixed-window rate limiter. A request is taken when start is high
// and busy is low; the table is scanned one entry per cycle, then the CALC
// state checks window expiry and the count limit, and UPDATE writes the entry.
// The answer shows on result, flagged by done for a single cycle, and
// cannot be held off by the receiver: capture it when done is high. A new
// request is not taken until the last one is through, and busy stays high
// meanwhile. Configuration is written through cfg_we/cfg_index/cfg_data;
// the user must write it only while busy is low and no result is pending,
// as the block itself does not enforce this.
module per_key_fixed_window_rate_limiter_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire fwrl_pkg::req_t                 request,
    output logic                                busy,
    output logic                                done,
    output fwrl_pkg::rsp_t                      result,
    input  wire logic                           cfg_we,
    input  wire logic [fwrl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fwrl_pkg::CFG_W-1:0]     cfg_data
);

    import fwrl_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TRACKED_ENTRIES - 1);

    // entry table
    logic [ADDR_W-1:0]  addr_mem  [TRACKED_ENTRIES];
    logic [TIME_W-1:0]  start_mem [TRACKED_ENTRIES];
    logic [COUNT_W-1:0] count_mem [TRACKED_ENTRIES];

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    req_t               req_reg, req_next;
    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic               free_reg, free_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic               expired_reg, expired_next;
    logic               cnt_le_reg, cnt_le_next;
    logic [COUNT_W-1:0] cnt_inc_reg, cnt_inc_next;
    logic [TIME_W-1:0]  window_reg;
    logic [LIMIT_W-1:0] max_reg;
    logic               done_reg, done_next;
    rsp_t               result_reg, result_next;

    logic               scan_live;
    logic               scan_match;
    logic [TIME_W-1:0]  elapsed;
    logic [COUNT_W-1:0] hit_count;
    logic [COUNT_W-1:0] max_ext;

    logic               wr_count_en;
    logic [IDX_W-1:0]   wr_count_idx;
    logic [COUNT_W-1:0] wr_count_val;
    logic               wr_entry_en;

    // shared compare path
    assign scan_live  = (count_mem[idx_reg] != '0);
    assign scan_match = scan_live && (addr_mem[idx_reg] == req_reg.ip_addr);
    assign hit_count  = count_mem[hit_idx_reg];
    assign elapsed    = req_reg.now_ms - start_mem[hit_idx_reg];
    assign max_ext    = {1'b0, max_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        idx_next      = idx_reg;
        req_next      = req_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        expired_next  = expired_reg;
        cnt_le_next   = cnt_le_reg;
        cnt_inc_next  = cnt_inc_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        wr_count_en   = 1'b0;
        wr_count_idx  = hit_idx_reg;
        wr_count_val  = '0;
        wr_entry_en   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next  = request;
                    idx_next  = '0;
                    hit_next  = 1'b0;
                    free_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (scan_match && !hit_reg)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = idx_reg;
                end
                if (!scan_live && !free_reg)
                begin
                    free_next     = 1'b1;
                    free_idx_next = idx_reg;
                end
                if (idx_reg != LAST_IDX)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_CALC:
            begin
                // wrapping difference, strictly greater means expired
                expired_next = (elapsed > window_reg);
                cnt_le_next  = (hit_count <= max_ext);
                cnt_inc_next = hit_count + 1'b1;
            end
            ST_UPDATE:
            begin
                done_next           = 1'b1;
                result_next.found   = hit_reg;
                result_next.allowed = 1'b0;
                if (req_reg.mode == MODE_CLEAR)
                begin
                    if (hit_reg)
                    begin
                        wr_count_en = 1'b1;
                    end
                end
                else if (!hit_reg)
                begin
                    // claim lowest free slot; table full denies
                    if (free_reg)
                    begin
                        wr_count_en         = 1'b1;
                        wr_count_idx        = free_idx_reg;
                        wr_count_val        = COUNT_W'(1);
                        wr_entry_en         = 1'b1;
                        result_next.allowed = 1'b1;
                    end
                end
                else if (expired_reg)
                begin
                    wr_count_en         = 1'b1;
                    wr_count_val        = COUNT_W'(1);
                    wr_entry_en         = 1'b1;
                    result_next.allowed = 1'b1;
                end
                else if (cnt_le_reg)
                begin
                    // count stops at limit + 1
                    wr_count_en         = 1'b1;
                    wr_count_val        = cnt_inc_reg;
                    result_next.allowed = (cnt_inc_reg <= max_ext);
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        req_reg      <= req_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        expired_reg  <= expired_next;
        cnt_le_reg   <= cnt_le_next;
        cnt_inc_reg  <= cnt_inc_next;
        result_reg   <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_MS_RESET;
            max_reg    <= MAX_REQUESTS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW_MS:
                begin
                    window_reg <= cfg_data[TIME_W-1:0];
                end
                REG_MAX_REQUESTS:
                begin
                    max_reg <= cfg_data[LIMIT_W-1:0];
                end
                default:
                begin
                    window_reg <= window_reg;
                end
            endcase
        end
    end

    // counts double as valid bits, so only they are reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TRACKED_ENTRIES; i++)
            begin
                count_mem[i] <= '0;
            end
        end
        else if (wr_count_en)
        begin
            count_mem[wr_count_idx] <= wr_count_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_entry_en)
        begin
            addr_mem[wr_count_idx]  <= req_reg.ip_addr;
            start_mem[wr_count_idx] <= req_reg.now_ms;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

/* sv/fwrl_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module fwrl_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire logic           done,
    input wire fwrl_pkg::rsp_t result
);

    import fwrl_pkg::*;

    // an accepted request always occupies the block
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    // a result only follows work in progress
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a request in progress");

    // the block is free again while the result is shown
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy still high with result strobe");

    // one strobe per request
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // the table scan always sits between accept and result
    a_no_result_early: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> !done)
        else $error("result strobe right after accept");

endmodule

bind per_key_fixed_window_rate_limiter_core fwrl_checker u_fwrl_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire
